[src/swmme_pkg.sv]
`default_nettype none

package swmme_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int MAX_LENGTH = 65536;
  localparam int SMP_W      = 16;
  localparam int POS_W      = $clog2(MAX_LENGTH);
  localparam int RAD_W      = 5;
  localparam int DEPTH      = 2 * MAX_RADIUS + 2;
  localparam int OUT_W      = 2 * SMP_W + 2 * POS_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int IN_BYTES_W  = ((SMP_W + 7) / 8) * 8;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SMP_W-1:0] val;
  } swmme_entry_t;

  // per-cycle command to a deque chain
  typedef struct packed {
    logic             clear;
    logic             push;
    logic             shift;
    logic             lim_en;
    logic [POS_W-1:0] limit;
  } swmme_ctl_t;

  // expiry status of the two leading entries
  typedef struct packed {
    logic exp0;
    logic exp1;
  } swmme_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_EMIT
  } swmme_state_e;

endpackage

`default_nettype wire

[src/swmme_cell.sv]
`default_nettype none

module swmme_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swmme_pkg::swmme_ctl_t   ctl_i,
  input  swmme_pkg::swmme_entry_t new_i,
  input  logic                 head_i,
  input  logic                 keep_prev_i,
  input  logic                 keep_next_i,
  input  swmme_pkg::swmme_entry_t next_i,
  output logic                 keep_o,
  output logic                 valid_o,
  output logic                 exp_o,
  output swmme_pkg::swmme_entry_t ent_o
);
  import swmme_pkg::*;

  logic         valid_q, valid_d;
  swmme_entry_t ent_q, ent_d;
  logic         dom;

  // entry is dominated when the new value is no larger
  assign dom     = ctl_i.push && ($signed(ent_q.val) >= $signed(new_i.val));
  assign keep_o  = valid_q && !dom;
  assign exp_o   = valid_q && ctl_i.lim_en && (ent_q.pos < ctl_i.limit);
  assign valid_o = valid_q;
  assign ent_o   = ent_q;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.shift) begin
      if (keep_next_i) begin
        valid_d = 1'b1;
        ent_d   = next_i;
      end else if (ctl_i.push && (head_i || keep_o)) begin
        valid_d = 1'b1;
        ent_d   = new_i;
      end else begin
        valid_d = 1'b0;
      end
    end else if (!keep_o) begin
      if (ctl_i.push && keep_prev_i) begin
        valid_d = 1'b1;
        ent_d   = new_i;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

[src/swmme_chain.sv]
`default_nettype none

module swmme_chain (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swmme_pkg::swmme_ctl_t   ctl_i,
  input  swmme_pkg::swmme_entry_t new_i,
  output swmme_pkg::swmme_entry_t head_o,
  output logic                    head_valid_o,
  output swmme_pkg::swmme_sts_t   sts_o
);
  import swmme_pkg::*;

  logic         keep  [DEPTH];
  logic         valid [DEPTH];
  logic         expd  [DEPTH];
  swmme_entry_t ent   [DEPTH];
  swmme_ctl_t   cell_ctl;

  // the head leaves whenever it has fallen out of the window
  always_comb begin
    cell_ctl       = ctl_i;
    cell_ctl.shift = expd[0];
  end

  assign sts_o.exp0   = expd[0];
  assign sts_o.exp1   = expd[1];
  assign head_o       = ent[0];
  assign head_valid_o = valid[0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic         kp, kn, hd;
    swmme_entry_t nx;
    if (k == 0) begin : g_first
      assign kp = 1'b1;
      assign hd = 1'b1;
    end else begin : g_mid
      assign kp = keep[k-1];
      assign hd = 1'b0;
    end
    if (k == DEPTH - 1) begin : g_last
      assign kn = 1'b0;
      assign nx = '0;
    end else begin : g_inner
      assign kn = keep[k+1];
      assign nx = ent[k+1];
    end

    swmme_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .new_i       (new_i),
      .head_i      (hd),
      .keep_prev_i (kp),
      .keep_next_i (kn),
      .next_i      (nx),
      .keep_o      (keep[k]),
      .valid_o     (valid[k]),
      .exp_o       (expd[k]),
      .ent_o       (ent[k])
    );
  end

endmodule

`default_nettype wire

[src/sliding_window_min_max_envelope.sv]
// Streaming min/max envelope of a signed series over a window of 2*radius+1
// samples, clipped at both ends of the series.
// Slave stream: one sample per transfer in s_axis_tdata, s_axis_tlast on the
// final sample of a series. Master stream: per position the window minimum,
// its position, the window maximum and its position; m_axis_tlast marks the
// result for the final position. Results come out in position order.
// Result p leaves once sample p+radius has been taken; the transfer with
// tlast flushes all pending results. A series that reaches 65536 samples
// ends at that sample.
// Each sample goes through take, deque update and emit, or through take and
// deque update alone while it releases no result yet; the next sample is
// taken only after that. After a radius decrease a deque update waits until
// no more than the head of each deque lies outside the window. The row of
// deque cells shifts at most one entry out of its head per cycle.
// The user writes radius via cfg_we_i/cfg_wdata_i between series or samples,
// unenforced by the block; a value so written applies from the next sample.
// After reset the deques are empty, the position is zero and radius is 5.
// A stalled master side holds one result in the output register; the next
// result waits for it, and no sample is taken while that result waits.
`default_nettype none

module sliding_window_min_max_envelope (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swmme_pkg::RAD_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swmme_pkg::IN_BYTES_W-1:0]    s_axis_tdata,  // sample
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // lower, lower_pos, upper, upper_pos
  output logic [swmme_pkg::OUT_BYTES_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast
);
  import swmme_pkg::*;

  swmme_state_e     state_q, state_d;
  logic [POS_W-1:0] pos_q, cur_q, p_q, p_end_q, p_start;
  logic [RAD_W-1:0] radius_q;
  logic [SMP_W-1:0] smp_q;
  logic             last_q;
  logic             m_valid_q, m_last_q;
  logic [OUT_W-1:0] m_data_q;

  logic [POS_W-1:0] r_ext, two_r;
  logic             accept, out_free, heads_ready, push_ok;
  logic             emit_go, finish;
  swmme_ctl_t       ctl;
  swmme_entry_t     min_new, max_new, min_head, max_head;
  logic             min_hv, max_hv;
  swmme_sts_t       min_sts, max_sts;
  logic [SMP_W-1:0] lower, upper;
  logic [POS_W-1:0] lower_pos, upper_pos;

  assign r_ext   = POS_W'(radius_q);
  assign two_r   = POS_W'({radius_q, 1'b0});
  assign p_start = (cur_q >= r_ext) ? (cur_q - r_ext) : '0;

  assign out_free    = !m_valid_q || m_axis_tready;
  assign heads_ready = !min_sts.exp0 && !max_sts.exp0;
  assign push_ok     = !min_sts.exp1 && !max_sts.exp1;
  assign accept      = s_axis_tready && s_axis_tvalid;

  // the max deque keeps inverted values so both chains keep the smallest
  assign min_new.pos = cur_q;
  assign min_new.val = smp_q;
  assign max_new.pos = cur_q;
  assign max_new.val = ~smp_q;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ctl           = '0;
    emit_go       = 1'b0;
    finish        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ctl.lim_en = cur_q >= two_r;
        ctl.limit  = cur_q - two_r;
        ctl.push   = push_ok;
        if (push_ok) begin
          if (!last_q && (cur_q < r_ext)) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        ctl.lim_en = p_q >= r_ext;
        ctl.limit  = p_q - r_ext;
        if (heads_ready && out_free) begin
          emit_go = 1'b1;
          if (p_q == p_end_q) begin
            finish    = 1'b1;
            ctl.clear = last_q;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  swmme_chain u_min (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .new_i        (min_new),
    .head_o       (min_head),
    .head_valid_o (min_hv),
    .sts_o        (min_sts)
  );

  swmme_chain u_max (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .new_i        (max_new),
    .head_o       (max_head),
    .head_valid_o (max_hv),
    .sts_o        (max_sts)
  );

  assign lower     = min_hv ? min_head.val : '0;
  assign lower_pos = min_hv ? min_head.pos : '0;
  assign upper     = max_hv ? ~max_head.val : '0;
  assign upper_pos = max_hv ? max_head.pos : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      radius_q  <= RAD_W'(5);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        radius_q <= (32'(cfg_wdata_i) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_wdata_i;
      end
      if (finish) begin
        pos_q <= last_q ? '0 : (cur_q + 1'b1);
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= pos_q;
      smp_q  <= s_axis_tdata[SMP_W-1:0];
      // a full-length series ends here whatever tlast says
      last_q <= s_axis_tlast || (pos_q == '1);
    end
    if (state_q == ST_PUSH) begin
      p_q     <= p_start;
      p_end_q <= last_q ? cur_q : (cur_q - r_ext);
    end else if (emit_go) begin
      p_q <= p_q + 1'b1;
    end
    if (emit_go) begin
      m_data_q <= {upper_pos, upper, lower_pos, lower};
      m_last_q <= last_q && (p_q == cur_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_BYTES_W'(m_data_q);
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

[dv/sliding_window_min_max_envelope_tb.sv]
module sliding_window_min_max_envelope_tb;
  import swmme_pkg::*;

  localparam int LO_SIDE = 0;
  localparam int HI_SIDE = 1;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_SAMPLES = 150;

  // highest field first; lower sits lowest, as on the master side
  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] upper_pos;
    logic [SMP_W-1:0] upper;
    logic [POS_W-1:0] lower_pos;
    logic [SMP_W-1:0] lower;
  } envelope_t;

  typedef struct {
    bit               wr;
    logic [RAD_W-1:0] rad;
    logic [SMP_W-1:0] smp;
    bit               lst;
    bit               typed;
    envelope_t        want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [RAD_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_BYTES_W-1:0] s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_BYTES_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  sliding_window_min_max_envelope dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // envelope predictor state: side 0 holds rising minima, side 1 falling maxima
  swmme_entry_t dq [2][DEPTH];
  int unsigned  dq_head [2];
  int unsigned  dq_cnt [2];
  int unsigned  series_pos;
  int unsigned  win_radius;

  envelope_t envelope_q[$];
  int        fail_cnt;
  bit        tx_gaps;
  bit        rx_gaps;
  row_t      dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic void dq_expire(input int s, input int unsigned lim);
    while (dq_cnt[s] > 0 && dq[s][dq_head[s]].pos < lim) begin
      dq_head[s] = (dq_head[s] + 1) % DEPTH;
      dq_cnt[s]--;
    end
  endfunction

  function automatic void dq_push(input int s, input int unsigned p,
                                  input logic signed [SMP_W-1:0] v);
    int unsigned            t;
    logic signed [SMP_W-1:0] tv;
    bit                     dominated;
    dominated = 1'b1;
    while (dq_cnt[s] > 0 && dominated) begin
      t = (dq_head[s] + dq_cnt[s] - 1) % DEPTH;
      tv = $signed(dq[s][t].val);
      dominated = (s == LO_SIDE) ? (tv >= v) : (tv <= v);
      if (dominated) dq_cnt[s]--;
    end
    if (dq_cnt[s] >= DEPTH) begin
      dq_head[s] = (dq_head[s] + 1) % DEPTH;
      dq_cnt[s]--;
    end
    t = (dq_head[s] + dq_cnt[s]) % DEPTH;
    dq[s][t].pos = p[POS_W-1:0];
    dq[s][t].val = v;
    dq_cnt[s]++;
  endfunction

  function automatic envelope_t window_extremes(input int unsigned p, input int unsigned r,
                                                input bit fin);
    envelope_t e;
    if (p >= r) begin
      dq_expire(LO_SIDE, p - r);
      dq_expire(HI_SIDE, p - r);
    end
    e = '0;
    if (dq_cnt[LO_SIDE] > 0) begin
      e.lower     = dq[LO_SIDE][dq_head[LO_SIDE]].val;
      e.lower_pos = dq[LO_SIDE][dq_head[LO_SIDE]].pos;
    end
    if (dq_cnt[HI_SIDE] > 0) begin
      e.upper     = dq[HI_SIDE][dq_head[HI_SIDE]].val;
      e.upper_pos = dq[HI_SIDE][dq_head[HI_SIDE]].pos;
    end
    e.last = fin;
    return e;
  endfunction

  function automatic void predict_sample(input logic signed [SMP_W-1:0] smp, input bit lst);
    int unsigned i;
    int unsigned r;
    int unsigned p;
    bit          fin;
    i = series_pos;
    r = win_radius;
    fin = lst || (i + 1 >= MAX_LENGTH);
    if (i >= 2 * r) begin
      dq_expire(LO_SIDE, i - 2 * r);
      dq_expire(HI_SIDE, i - 2 * r);
    end
    dq_push(LO_SIDE, i, smp);
    dq_push(HI_SIDE, i, smp);
    if (i >= r) envelope_q = {envelope_q, window_extremes(i - r, r, fin && r == 0)};
    if (fin) begin
      // flush every pending position, then start a new series
      p = (i >= r) ? i - r + 1 : 0;
      for (; p <= i && r > 0; p++) envelope_q = {envelope_q, window_extremes(p, r, p == i)};
      series_pos = 0;
      for (int s = 0; s < 2; s++) begin
        dq_head[s] = 0;
        dq_cnt[s] = 0;
      end
    end else begin
      series_pos = i + 1;
    end
  endfunction

  task automatic send_sample(input logic [SMP_W-1:0] smp, input bit lst,
                             input bit typed, input envelope_t want);
    int gap;
    int n0;
    gap = tx_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    n0 = envelope_q.size();
    predict_sample(smp, lst);
    if (typed) begin
      while (envelope_q.size() > n0) void'(envelope_q.pop_back());
      envelope_q = {envelope_q, want};
    end
  endtask

  // radius may only change once nothing is in flight
  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] rad);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rad;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_radius = (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
  endtask

  function automatic void add_row(input bit wr, input logic [RAD_W-1:0] rad,
                                  input logic [SMP_W-1:0] smp, input bit lst,
                                  input bit typed, input logic [SMP_W-1:0] lo,
                                  input logic [POS_W-1:0] lo_pos,
                                  input logic [SMP_W-1:0] hi,
                                  input logic [POS_W-1:0] hi_pos, input bit fin);
    row_t row;
    row.wr = wr;
    row.rad = rad;
    row.smp = smp;
    row.lst = lst;
    row.typed = typed;
    row.want = '{last: fin, upper_pos: hi_pos, upper: hi, lower_pos: lo_pos, lower: lo};
    dir_rows = {dir_rows, row};
  endfunction

  // result side
  initial begin
    envelope_t got;
    envelope_t want;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_gaps ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = envelope_t'({m_axis_tlast, m_axis_tdata[OUT_W-1:0]});
      if (envelope_q.size() == 0) begin
        note_fail($sformatf("unexpected transfer lo %0d@%0d hi %0d@%0d last %0b",
                            $signed(got.lower), got.lower_pos, $signed(got.upper),
                            got.upper_pos, got.last));
      end else begin
        want = envelope_q.pop_front();
        if (got.lower !== want.lower || got.lower_pos !== want.lower_pos ||
            got.upper !== want.upper || got.upper_pos !== want.upper_pos ||
            got.last !== want.last) begin
          note_fail($sformatf(
            "mismatch: exp lo %0d@%0d hi %0d@%0d last %0b, got lo %0d@%0d hi %0d@%0d last %0b",
            $signed(want.lower), want.lower_pos, $signed(want.upper), want.upper_pos,
            want.last, $signed(got.lower), got.lower_pos, $signed(got.upper),
            got.upper_pos, got.last));
        end
      end
    end
  end

  // sample side
  initial begin
    int sent;
    int len;
    int mode;
    logic [RAD_W-1:0] rad;
    logic [SMP_W-1:0] val;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    fail_cnt      = 0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    series_pos    = 0;
    win_radius    = 5;
    for (int s = 0; s < 2; s++) begin
      dq_head[s] = 0;
      dq_cnt[s] = 0;
    end

    // one-sample series at reset radius, extreme values
    add_row(1'b0, 5'd0, 16'h8000, 1'b1, 1'b1, 16'h8000, 16'd0, 16'h8000, 16'd0, 1'b1);
    add_row(1'b0, 5'd0, 16'h7fff, 1'b1, 1'b1, 16'h7fff, 16'd0, 16'h7fff, 16'd0, 1'b1);
    // zero radius: each sample is its own window
    add_row(1'b1, 5'd0, 16'hffff, 1'b0, 1'b1, 16'hffff, 16'd0, 16'hffff, 16'd0, 1'b0);
    add_row(1'b0, 5'd0, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'd1, 16'h0000, 16'd1, 1'b1);
    // largest radius on a series shorter than it, ties resolve to the latest
    add_row(1'b1, 5'd31, 16'd7, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, -16'sd3, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, -16'sd3, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd7, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    // radius 2, shrunk to 1 in the middle of the series
    add_row(1'b1, 5'd2, 16'd1, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd5, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd2, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, -16'sd8, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b1, 5'd1, 16'd3, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd3, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd9, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0);
    add_row(1'b0, 5'd0, 16'd0, 1'b1, 1'b0, '0, '0, '0, '0, 1'b0);
    // flat series
    for (int k = 0; k < 5; k++) add_row(k == 0, 5'd3, 16'd4, k == 4, 1'b0, '0, '0, '0, '0, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[j]) begin
      if (dir_rows[j].wr) begin
        go_idle();
        write_radius(dir_rows[j].rad);
      end
      send_sample(dir_rows[j].smp, dir_rows[j].lst, dir_rows[j].typed, dir_rows[j].want);
    end

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 5))
        0:       rad = '0;
        1:       rad = RAD_W'(MAX_RADIUS);
        default: rad = RAD_W'($urandom_range(0, MAX_RADIUS));
      endcase
      go_idle();
      write_radius(rad);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) len = $urandom_range(1, (rad > 0) ? rad : 1);
      else len = $urandom_range(1, 48);
      mode = $urandom_range(0, 3);
      val = SMP_W'($urandom_range(0, 65535));
      for (int k = 0; k < len; k++) begin
        if (k > 0 && $urandom_range(0, 15) == 0) begin
          go_idle();
          write_radius(RAD_W'($urandom_range(0, MAX_RADIUS)));
        end
        // full range, narrow range for ties, rising and falling runs
        case (mode)
          0:       val = SMP_W'($urandom_range(0, 65535));
          1:       val = SMP_W'($urandom_range(0, 6) - 3);
          2:       val = SMP_W'(val + $urandom_range(0, 300));
          default: val = SMP_W'(val - $urandom_range(0, 300));
        endcase
        send_sample(val, k == len - 1, 1'b0, '0);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/swmme_pkg.sv
src/swmme_cell.sv
src/swmme_chain.sv
src/sliding_window_min_max_envelope.sv
dv/sliding_window_min_max_envelope_tb.sv
